@@ hw/rtl/rvalu_pkg.sv @@
// Package for the RV64IM integer execute unit: operation codes, widths and
// the per-stage record that travels down the divide and multiply chain. No dependencies.
package rvalu_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned MODE_W = 5;
  localparam int unsigned DEF_BITS_PER_CELL = 2;

  typedef enum logic [MODE_W-1:0] {
    OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_SLL  = 5'd2,  OP_SLT  = 5'd3,
    OP_SLTU = 5'd4,  OP_XOR  = 5'd5,  OP_SRL  = 5'd6,  OP_SRA  = 5'd7,
    OP_OR   = 5'd8,  OP_AND  = 5'd9,  OP_MUL  = 5'd10, OP_DIV  = 5'd11,
    OP_REM  = 5'd12, OP_ADDW = 5'd13, OP_SUBW = 5'd14, OP_SLLW = 5'd15,
    OP_SRLW = 5'd16, OP_SRAW = 5'd17, OP_MULW = 5'd18, OP_DIVW = 5'd19,
    OP_REMW = 5'd20, OP_MV   = 5'd21, OP_NOT  = 5'd22, OP_NEG  = 5'd23,
    OP_NEGW = 5'd24, OP_SEQZ = 5'd25, OP_SNEZ = 5'd26
  } op_t;

  // Request record carried by every cell of the chain.
  typedef struct packed {
    logic            vld;
    logic            is_div;   // Result comes from the divider.
    logic            is_mul;   // Result comes from the multiplier.
    logic            want_rem;
    logic            word;
    logic            neg_q;
    logic            neg_r;
    logic [XLEN-1:0] rem;      // Partial remainder, or product accumulator.
    logic [XLEN-1:0] quo;      // Dividend or multiplier shifting out, quotient shifting in.
    logic [XLEN-1:0] dvs;      // Divisor magnitude, or shifted multiplicand.
    logic [XLEN-1:0] res;      // Early result for all other operations.
  } stage_t;

  function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] x);
    sext32 = {{(XLEN-32){x[31]}}, x[31:0]};
  endfunction

endpackage

@@ hw/rtl/rvalu_cell.sv @@
// One cell of the divide and multiply chain: retires BITS quotient or multiplier
// bits per cycle while adv is high, passes the request record on. Depends on rvalu_pkg.
module rvalu_cell #(
  parameter int unsigned BITS = rvalu_pkg::DEF_BITS_PER_CELL
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  rvalu_pkg::stage_t d_in,
  output rvalu_pkg::stage_t d_out
);
  rvalu_pkg::stage_t cur_r, cur_nxt;
  logic [rvalu_pkg::XLEN:0] trial;
  logic [rvalu_pkg::XLEN-1:0] r_w, q_w, m_w;

  always_comb begin
    cur_nxt = d_in;
    r_w = d_in.rem;
    q_w = d_in.quo;
    m_w = d_in.dvs;
    trial = '0;
    if (d_in.is_div) begin
      for (int i = 0; i < BITS; i++) begin
        trial = {r_w, q_w[rvalu_pkg::XLEN-1]} - {1'b0, d_in.dvs};
        if (!trial[rvalu_pkg::XLEN]) begin
          r_w = trial[rvalu_pkg::XLEN-1:0];
          q_w = {q_w[rvalu_pkg::XLEN-2:0], 1'b1};
        end else begin
          r_w = {r_w[rvalu_pkg::XLEN-2:0], q_w[rvalu_pkg::XLEN-1]};
          q_w = {q_w[rvalu_pkg::XLEN-2:0], 1'b0};
        end
      end
    end else if (d_in.is_mul) begin
      // Shift-and-add: only the low product bits are kept.
      for (int i = 0; i < BITS; i++) begin
        if (q_w[0]) begin
          r_w = r_w + m_w;
        end
        m_w = {m_w[rvalu_pkg::XLEN-2:0], 1'b0};
        q_w = {1'b0, q_w[rvalu_pkg::XLEN-1:1]};
      end
    end
    cur_nxt.rem = r_w;
    cur_nxt.quo = q_w;
    cur_nxt.dvs = m_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.vld <= 1'b0;
    end else if (adv) begin
      cur_r <= cur_nxt;
    end
  end

  assign d_out = cur_r;
endmodule

@@ hw/rtl/rv64_integer_alu.sv @@
// Top level of the RV64IM integer execute unit: front decode, a chain of
// divide and multiply cells and a result register. Depends on rvalu_pkg, rvalu_cell.
//
//  channel  ports                               direction
//  in       in_valid in_stall in_mode in_operand_a in_operand_b   request in
//  out      out_valid out_stall out_result_value                 result out
//
// One request enters each cycle while in_stall is low; every request, whatever
// its operation, passes the head register, the cell chain that both the divider
// and the multiplier run through, and the result register.
// The whole chain moves together; a stall on a valid output freezes every stage.
// Reset clears the valid bits only.
module rv64_integer_alu #(
  parameter int unsigned BITS_PER_CELL = rvalu_pkg::DEF_BITS_PER_CELL
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rvalu_pkg::MODE_W-1:0]  in_mode,
  input  logic [rvalu_pkg::XLEN-1:0]    in_operand_a,
  input  logic [rvalu_pkg::XLEN-1:0]    in_operand_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rvalu_pkg::XLEN-1:0]    out_result_value
);
  localparam int unsigned XL = rvalu_pkg::XLEN;
  localparam int unsigned NCELL = XL / BITS_PER_CELL;

  rvalu_pkg::stage_t chain [NCELL+1];
  rvalu_pkg::stage_t head_r, head_nxt;
  logic adv;
  logic [XL-1:0] out_r, out_nxt;
  logic          ov_r;
  logic [XL-1:0] a, b, mag_a, mag_b;
  logic [5:0] sh;
  logic [4:0] sh5;
  logic sa, sb, dz, ovf;
  rvalu_pkg::op_t op;

  assign adv = !(ov_r && out_stall);
  assign in_stall = !adv;

  assign a = in_operand_a;
  assign b = in_operand_b;
  assign sh = b[5:0];
  assign sh5 = b[4:0];
  assign op = rvalu_pkg::op_t'(in_mode);

  always_comb begin
    logic [XL-1:0] a32s, b32s;
    logic word;
    a32s = rvalu_pkg::sext32(a);
    b32s = rvalu_pkg::sext32(b);
    word = (op == rvalu_pkg::OP_DIVW) || (op == rvalu_pkg::OP_REMW) ||
           (op == rvalu_pkg::OP_MULW);
    head_nxt = '0;
    head_nxt.vld = in_valid;
    head_nxt.word = word;
    sa = word ? a32s[XL-1] : a[XL-1];
    sb = word ? b32s[XL-1] : b[XL-1];
    mag_a = word ? (sa ? -a32s : a32s) : (sa ? -a : a);
    mag_b = word ? (sb ? -b32s : b32s) : (sb ? -b : b);
    dz = word ? (b[31:0] == 32'd0) : (b == '0);
    ovf = word ? (a[31:0] == 32'h8000_0000 && b[31:0] == 32'hFFFF_FFFF)
               : (a == {1'b1, {(XL-1){1'b0}}} && b == '1);
    unique case (op)
      rvalu_pkg::OP_ADD:  head_nxt.res = a + b;
      rvalu_pkg::OP_SUB:  head_nxt.res = a - b;
      rvalu_pkg::OP_SLL:  head_nxt.res = a << sh;
      rvalu_pkg::OP_SLT:  head_nxt.res = {{(XL-1){1'b0}}, $signed(a) < $signed(b)};
      rvalu_pkg::OP_SLTU: head_nxt.res = {{(XL-1){1'b0}}, a < b};
      rvalu_pkg::OP_XOR:  head_nxt.res = a ^ b;
      rvalu_pkg::OP_SRL:  head_nxt.res = a >> sh;
      rvalu_pkg::OP_SRA:  head_nxt.res = XL'($signed(a) >>> sh);
      rvalu_pkg::OP_OR:   head_nxt.res = a | b;
      rvalu_pkg::OP_AND:  head_nxt.res = a & b;
      rvalu_pkg::OP_MUL, rvalu_pkg::OP_MULW: begin
        // The product is built BITS_PER_CELL bits per cell along the chain.
        head_nxt.is_mul = 1'b1;
        head_nxt.quo = b;
        head_nxt.dvs = a;
      end
      rvalu_pkg::OP_ADDW: head_nxt.res = rvalu_pkg::sext32(a + b);
      rvalu_pkg::OP_SUBW: head_nxt.res = rvalu_pkg::sext32(a - b);
      rvalu_pkg::OP_SLLW: head_nxt.res = rvalu_pkg::sext32(a << sh5);
      rvalu_pkg::OP_SRLW: head_nxt.res = rvalu_pkg::sext32({32'd0, a[31:0] >> sh5});
      rvalu_pkg::OP_SRAW: head_nxt.res = XL'($signed(a32s) >>> sh5);
      rvalu_pkg::OP_DIV, rvalu_pkg::OP_REM, rvalu_pkg::OP_DIVW,
      rvalu_pkg::OP_REMW: begin
        // Zero divisor and overflow take their result from decode; others divide in the chain.
        if (dz) begin
          head_nxt.res = (op == rvalu_pkg::OP_DIV || op == rvalu_pkg::OP_DIVW) ? '1
                        : (word ? a32s : a);
        end else if (ovf) begin
          head_nxt.res = (op == rvalu_pkg::OP_DIV) ? a
                        : (op == rvalu_pkg::OP_DIVW) ? a32s : '0;
        end else begin
          head_nxt.is_div = 1'b1;
          head_nxt.want_rem = (op == rvalu_pkg::OP_REM) || (op == rvalu_pkg::OP_REMW);
          head_nxt.neg_q = sa ^ sb;
          head_nxt.neg_r = sa;
          head_nxt.quo = mag_a;
          head_nxt.dvs = mag_b;
        end
      end
      rvalu_pkg::OP_MV:   head_nxt.res = a;
      rvalu_pkg::OP_NOT:  head_nxt.res = ~a;
      rvalu_pkg::OP_NEG:  head_nxt.res = -a;
      rvalu_pkg::OP_NEGW: head_nxt.res = rvalu_pkg::sext32(-a);
      rvalu_pkg::OP_SEQZ: head_nxt.res = {{(XL-1){1'b0}}, a == '0};
      rvalu_pkg::OP_SNEZ: head_nxt.res = {{(XL-1){1'b0}}, a != '0};
      default:            head_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
    end else if (adv) begin
      head_r <= head_nxt;
    end
  end

  assign chain[0] = head_r;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    rvalu_cell #(.BITS(BITS_PER_CELL)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .d_in (chain[g]),
      .d_out(chain[g+1])
    );
  end

  always_comb begin
    rvalu_pkg::stage_t t;
    logic [XL-1:0] v;
    t = chain[NCELL];
    v = t.want_rem ? (t.neg_r ? -t.rem : t.rem) : (t.neg_q ? -t.quo : t.quo);
    out_nxt = t.is_mul ? (t.word ? rvalu_pkg::sext32(t.rem) : t.rem)
            : t.is_div ? (t.word ? rvalu_pkg::sext32(v) : v) : t.res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= chain[NCELL].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_result_value = out_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value))
    else $error("result changed under stall");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |=> out_valid == $past(chain[NCELL].vld))
    else $error("chain valid lost");
endmodule

@@ verif/rv64_integer_alu_tb.sv @@
// Testbench for rv64_integer_alu: drives requests through the valid/stall
// handshake and compares each result with a built-in RV64IM predictor.
// Depends on rvalu_pkg and rv64_integer_alu.
`timescale 1ns / 1ps

module rv64_integer_alu_tb;

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL1 = '1;
  localparam logic [63:0] INT32_MIN_X = 64'hFFFF_FFFF_8000_0000;
  localparam int LATENCY = 64 / rvalu_pkg::DEF_BITS_PER_CELL + 2;
  localparam int HANG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [rvalu_pkg::MODE_W-1:0] in_mode = '0;
  logic [63:0] in_operand_a = '0;
  logic [63:0] in_operand_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] out_result_value;

  logic [63:0] expected_values[$];
  int n_errors = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_recv = 1'b0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  rv64_integer_alu uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] sx32(input logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  function automatic logic [63:0] signed_divide(input logic [63:0] a, input logic [63:0] b,
                                                input bit want_rem);
    logic [63:0] ma, mb, q, r;
    if (b == 0) return want_rem ? a : ALL1;
    if (a == SIGN64 && b == ALL1) return want_rem ? 64'd0 : SIGN64;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (want_rem) return a[63] ? -r : r;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic logic [63:0] alu_result(input logic [4:0] mode, input logic [63:0] a,
                                             input logic [63:0] b);
    logic [5:0] s64;
    logic [4:0] s32;
    s64 = b[5:0];
    s32 = b[4:0];
    case (mode)
      rvalu_pkg::OP_ADD:  return a + b;
      rvalu_pkg::OP_SUB:  return a - b;
      rvalu_pkg::OP_SLL:  return a << s64;
      rvalu_pkg::OP_SLT:  return {63'd0, $signed(a) < $signed(b)};
      rvalu_pkg::OP_SLTU: return {63'd0, a < b};
      rvalu_pkg::OP_XOR:  return a ^ b;
      rvalu_pkg::OP_SRL:  return a >> s64;
      rvalu_pkg::OP_SRA:  return $signed(a) >>> s64;
      rvalu_pkg::OP_OR:   return a | b;
      rvalu_pkg::OP_AND:  return a & b;
      rvalu_pkg::OP_MUL:  return a * b;
      rvalu_pkg::OP_DIV:  return signed_divide(a, b, 1'b0);
      rvalu_pkg::OP_REM:  return signed_divide(a, b, 1'b1);
      rvalu_pkg::OP_ADDW: return sx32(a + b);
      rvalu_pkg::OP_SUBW: return sx32(a - b);
      rvalu_pkg::OP_SLLW: return sx32({32'd0, a[31:0]} << s32);
      rvalu_pkg::OP_SRLW: return sx32({32'd0, a[31:0]} >> s32);
      rvalu_pkg::OP_SRAW: return sx32($signed(sx32(a)) >>> s32);
      rvalu_pkg::OP_MULW: return sx32({32'd0, a[31:0]} * {32'd0, b[31:0]});
      rvalu_pkg::OP_DIVW:
        return (b[31:0] == 0) ? ALL1 : sx32(signed_divide(sx32(a), sx32(b), 1'b0));
      rvalu_pkg::OP_REMW:
        return (b[31:0] == 0) ? sx32(a) : sx32(signed_divide(sx32(a), sx32(b), 1'b1));
      rvalu_pkg::OP_MV:   return a;
      rvalu_pkg::OP_NOT:  return ~a;
      rvalu_pkg::OP_NEG:  return -a;
      rvalu_pkg::OP_NEGW: return sx32(-a);
      rvalu_pkg::OP_SEQZ: return {63'd0, a == 0};
      rvalu_pkg::OP_SNEZ: return {63'd0, a != 0};
      default: return 64'd0;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = 64'($urandom_range(0, 3));
      1: v = ALL1 - 64'($urandom_range(0, 3));
      2: v = SIGN64 ^ 64'($urandom_range(0, 1));
      3: v = sx32({32'd0, $urandom});
      4: v = 64'($urandom_range(0, 70));
      5: v = INT32_MIN_X;
      default: ;
    endcase
    return v;
  endfunction

  // Holds the request until accepted, with a random gap before it when idling is on.
  task automatic send_request(input logic [4:0] mode, input logic [63:0] a,
                              input logic [63:0] b);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_operand_a <= a;
    in_operand_b <= b;
    expected_values = {expected_values, alu_result(mode, a, b)};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [63:0] edges[6];
    edges = '{64'd0, 64'd1, ALL1, SIGN64, ~SIGN64, INT32_MIN_X};
    for (int m = 0; m < 32; m++) send_request(m[4:0], edges[m % 6], edges[(m + 2) % 6]);
    send_request(rvalu_pkg::OP_DIV, SIGN64, ALL1);
    send_request(rvalu_pkg::OP_REM, SIGN64, ALL1);
    send_request(rvalu_pkg::OP_DIVW, INT32_MIN_X, ALL1);
    send_request(rvalu_pkg::OP_REMW, 64'h1234_5678_8000_0000, 64'hFFFF_FFFF);
    send_request(rvalu_pkg::OP_DIV, 64'd7, 64'd0);
    send_request(rvalu_pkg::OP_REM, 64'd7, 64'd0);
    send_request(rvalu_pkg::OP_DIVW, 64'h5, 64'hABCD_0000_0000);
    send_request(rvalu_pkg::OP_REMW, 64'hFFFF_0000_8765_4321, 64'h1_0000_0000);
    send_request(rvalu_pkg::OP_SLL, 64'd1, 64'hFFC0 | 63);
    send_request(rvalu_pkg::OP_SRAW, 64'h8000_0000, 64'd31 | 64'h20);
  endtask

  task automatic test_random(input int count);
    logic [4:0] mode;
    for (int i = 0; i < count; i++) begin
      mode = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(27, 31))
                                          : 5'($urandom_range(0, 26));
      send_request(mode, rand64(), rand64());
    end
  endtask

  // The receiver holds off long enough to fill the chain and stall the input.
  task automatic test_backpressure();
    hold_cycles = 3 * LATENCY;
    hold_recv = 1'b1;
    for (int i = 0; i < 3 * LATENCY; i++) send_request(rvalu_pkg::OP_DIV, rand64(), rand64());
    wait_drained();
    test_random(20);
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_backpressure();
    test_random(500);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    wait_drained();
    repeat (15) @(posedge clk);
    test_random(100);
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    if (n_errors == 0 && expected_values.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver stall: random bursts, plus a long counted hold-off when requested.
  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (hold_recv) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_recv = 1'b0;
        out_stall <= 1'b0;
      end else if (recv_idle && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    logic [63:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_values.size() == 0) begin
        $error("unexpected result_value %h", out_result_value);
        n_errors++;
      end else begin
        want = expected_values.pop_front();
        if (out_result_value !== want) begin
          $error("result_value expected %h actual %h", want, out_result_value);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

@@ sim.f @@
hw/rtl/rvalu_pkg.sv
hw/rtl/rvalu_cell.sv
hw/rtl/rv64_integer_alu.sv
verif/rv64_integer_alu_tb.sv
